FILE: rtl/clt_pkg.sv
// shared types and constants for the chat line tokenizer
`timescale 1ns / 1ps
`default_nettype none

package clt_pkg;

  localparam int unsigned LineLimitDef = 512;
  localparam int unsigned MaxTokensDef = 10;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChSpace = 8'h20;

  typedef enum logic [2:0] {
    KIND_PREFIX   = 3'd0,
    KIND_WORD     = 3'd1,
    KIND_FIRST_SP = 3'd2,
    KIND_EXTRA_SP = 3'd3,
    KIND_TRAILING = 3'd4,
    KIND_COLON    = 3'd5
  } kind_e;

  // per-line scan state, apart from the length counter
  typedef struct packed {
    logic       in_ws;
    logic [3:0] tokens;
    logic       prefix;
    logic       stopped;
    logic       trailing;
    logic       overflow;
  } scan_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    logic [3:0] token_index;
    logic       line_end;
    logic [3:0] token_count;
    logic       has_prefix;
    logic       truncated;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/clt_classify.sv
// per-byte classification and next line state
`timescale 1ns / 1ps
`default_nettype none

module clt_classify import clt_pkg::*; #(
  parameter int unsigned LINE_LIMIT = LineLimitDef,
  parameter int unsigned MAX_TOKENS = MaxTokensDef,
  localparam int unsigned LenW = $clog2(LINE_LIMIT)
) (
  input  logic [7:0]      byte_i,
  input  scan_t           scan_i,
  input  logic [LenW-1:0] len_i,
  output scan_t           scan_o,
  output logic [LenW-1:0] len_o,
  output logic            res_valid_o,
  output result_t         res_o
);

  localparam logic [LenW-1:0] LenMax = LenW'(LINE_LIMIT - 1);
  localparam logic [3:0]      TokMax = 4'(MAX_TOKENS);

  logic       line_start;
  logic [3:0] tok;
  logic [3:0] tok_inc;
  logic [3:0] cur_idx;
  logic [3:0] inc_idx;

  assign line_start = (len_i == '0);
  // a non-colon first byte opens token one
  assign tok     = line_start ? 4'd1 : scan_i.tokens;
  assign tok_inc = tok + 4'd1;
  assign cur_idx = (tok == 4'd0) ? 4'd0 : tok - 4'd1;
  assign inc_idx = tok;

  always_comb begin
    scan_o      = scan_i;
    len_o       = len_i;
    res_valid_o = 1'b0;
    res_o       = '{out_byte: byte_i, kind: KIND_PREFIX, token_index: 4'd0,
                    line_end: 1'b0, token_count: 4'd0, has_prefix: 1'b0,
                    truncated: 1'b0};
    if (byte_i == ChNul) begin
      res_valid_o = 1'b0;
    end else if (byte_i == ChCr || byte_i == ChLf) begin
      res_valid_o       = !line_start;
      res_o.out_byte    = 8'd0;
      res_o.line_end    = 1'b1;
      res_o.token_count = scan_i.tokens;
      res_o.has_prefix  = scan_i.prefix;
      res_o.truncated   = scan_i.overflow;
      scan_o            = '0;
      len_o             = '0;
    end else if (len_i >= LenMax) begin
      scan_o.overflow = 1'b1;
    end else begin
      res_valid_o = 1'b1;
      len_o       = len_i + 1'b1;
      if (line_start && byte_i == ChColon) begin
        scan_o.prefix = 1'b1;
        scan_o.tokens = 4'd0;
        res_o.kind    = KIND_COLON;
      end else begin
        scan_o.tokens = tok;
        if (scan_i.stopped) begin
          res_o.kind        = scan_i.trailing ? KIND_TRAILING : KIND_WORD;
          res_o.token_index = cur_idx;
        end else if (scan_i.in_ws) begin
          if (byte_i == ChColon) begin
            scan_o.tokens   = tok_inc;
            scan_o.stopped  = 1'b1;
            scan_o.trailing = 1'b1;
            res_o.kind      = KIND_COLON;
          end else if (byte_i == ChSpace) begin
            res_o.kind = KIND_EXTRA_SP;
          end else begin
            scan_o.tokens     = tok_inc;
            scan_o.in_ws      = 1'b0;
            res_o.kind        = KIND_WORD;
            res_o.token_index = inc_idx;
            if (tok_inc >= TokMax) begin
              scan_o.stopped = 1'b1;
            end
          end
        end else if (byte_i == ChSpace) begin
          res_o.kind   = KIND_FIRST_SP;
          scan_o.in_ws = 1'b1;
        end else if (scan_i.prefix && tok == 4'd0) begin
          res_o.kind = KIND_PREFIX;
        end else begin
          res_o.kind        = KIND_WORD;
          res_o.token_index = cur_idx;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/clt_out_stage.sv
// result register with valid/ready handshake
`timescale 1ns / 1ps
`default_nettype none

module clt_out_stage import clt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // free when empty or the held beat leaves this cycle
  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

FILE: rtl/chat_line_tokenizer_top.sv
// top level of the chat line tokenizer
//
//   channel  dir  handshake                 payload
//   in       in   in_valid_i / in_ready_o   in_byte_i
//   out      out  out_valid_o / out_ready_i out_byte_o kind_o token_index_o line_end_o
//                                           token_count_o has_prefix_o truncated_o
//
// one byte per cycle while in_ready_o is high; the scan state updates in the
// accept cycle and the result appears from the result register in the next cycle
// in_ready_o is low only while a held result is stalled by out_ready_i low
// reset clears the line state and empties the result register
// nul, empty line ends and dropped overlong bytes give no output beat
`timescale 1ns / 1ps
`default_nettype none

module chat_line_tokenizer_top import clt_pkg::*; #(
  parameter int unsigned LINE_LIMIT = LineLimitDef,
  parameter int unsigned MAX_TOKENS = MaxTokensDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] kind_o,
  output logic [3:0] token_index_o,
  output logic       line_end_o,
  output logic [3:0] token_count_o,
  output logic       has_prefix_o,
  output logic       truncated_o
);

  localparam int unsigned LenW = $clog2(LINE_LIMIT);

  scan_t           scan_q, scan_d;
  logic [LenW-1:0] len_q, len_d;
  logic            res_valid;
  result_t         res;
  result_t         res_out;
  logic            accept;
  logic            free;

  assign in_ready_o = free;
  assign accept     = in_valid_i && free;

  clt_classify #(
    .LINE_LIMIT(LINE_LIMIT),
    .MAX_TOKENS(MAX_TOKENS)
  ) u_classify (
    .byte_i     (in_byte_i),
    .scan_i     (scan_q),
    .len_i      (len_q),
    .scan_o     (scan_d),
    .len_o      (len_d),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
      len_q  <= '0;
    end else if (accept) begin
      scan_q <= scan_d;
      len_q  <= len_d;
    end
  end

  clt_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept && res_valid),
    .res_i  (res),
    .free_o (free),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .res_o  (res_out)
  );

  assign out_byte_o    = res_out.out_byte;
  assign kind_o        = res_out.kind;
  assign token_index_o = res_out.token_index;
  assign line_end_o    = res_out.line_end;
  assign token_count_o = res_out.token_count;
  assign has_prefix_o  = res_out.has_prefix;
  assign truncated_o   = res_out.truncated;

endmodule

`default_nettype wire
